// ===== design/meba_pkg.sv =====
// ----------------------------------------------------------------------------
// meba_pkg
// Shared types and constants of the mouse event burst assembler.
// ----------------------------------------------------------------------------
package meba_pkg;

    localparam logic [1:0] KIND_MOVE = 2'd0;
    localparam logic [1:0] KIND_DRAG = 2'd1;
    localparam logic [1:0] KIND_DOWN = 2'd2;
    localparam logic [1:0] KIND_UP   = 2'd3;

    // one closed burst, as handed from front to back
    typedef struct packed {
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic signed [15:0] wheel_move;
        logic [1:0]         kind;
        logic [2:0]         mask;
        logic [2:0]         deferred;
    } packet_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== design/meba_front.sv =====
// ----------------------------------------------------------------------------
// meba_front
// Decodes events, keeps burst accumulators and button masks, closes a burst
// into a packet descriptor on sync.
// ----------------------------------------------------------------------------
module meba_front
    import meba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [15:0]        event_type,
    input  logic [15:0]        event_code,
    input  logic signed [31:0] event_value,
    output logic               pkt_valid,
    output packet_t            pkt
);

    localparam logic [15:0] TYPE_SYNC   = 16'h0000;
    localparam logic [15:0] TYPE_KEY    = 16'h0001;
    localparam logic [15:0] TYPE_REL    = 16'h0002;
    localparam logic [15:0] AXIS_X      = 16'h0000;
    localparam logic [15:0] AXIS_Y      = 16'h0001;
    localparam logic [15:0] AXIS_WHEEL  = 16'h0008;
    localparam logic [15:0] CODE_LEFT   = 16'h0110;
    localparam logic [15:0] CODE_RIGHT  = 16'h0111;
    localparam logic [15:0] CODE_MIDDLE = 16'h0112;

    // only the low 16 bits of each sum ever leave the block
    logic [15:0] sum_x_reg, sum_x_next;
    logic [15:0] sum_y_reg, sum_y_next;
    logic [15:0] sum_w_reg, sum_w_next;
    logic [2:0]  pressed_reg, pressed_next;
    logic [2:0]  released_reg, released_next;
    logic [2:0]  held_reg, held_next;
    logic [2:0]  deferred_reg, deferred_next;
    logic [2:0]  btn;
    logic [15:0] delta;

    assign delta = event_value[15:0];

    always_comb
    begin
        case (event_code)
            CODE_LEFT:   btn = 3'b001;
            CODE_RIGHT:  btn = 3'b010;
            CODE_MIDDLE: btn = 3'b100;
            default:     btn = 3'b000;
        endcase
    end

    always_comb
    begin
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        sum_w_next    = sum_w_reg;
        pressed_next  = pressed_reg;
        released_next = released_reg;
        held_next     = held_reg;
        deferred_next = deferred_reg;
        pkt_valid     = 1'b0;

        pkt.move_x     = sum_x_reg;
        pkt.move_y     = sum_y_reg;
        pkt.wheel_move = sum_w_reg;
        pkt.deferred   = deferred_reg;
        if (pressed_reg != 3'b000)
        begin
            pkt.kind = KIND_DOWN;
            pkt.mask = pressed_reg;
        end
        else if (released_reg != 3'b000)
        begin
            pkt.kind = KIND_UP;
            pkt.mask = released_reg;
        end
        else if (held_reg != 3'b000)
        begin
            pkt.kind = KIND_DRAG;
            pkt.mask = held_reg;
        end
        else
        begin
            pkt.kind = KIND_MOVE;
            pkt.mask = 3'b000;
        end

        if (accept)
        begin
            case (event_type)
                TYPE_REL:
                begin
                    if (event_code == AXIS_X)
                        sum_x_next = sum_x_reg + delta;
                    else if (event_code == AXIS_Y)
                        sum_y_next = sum_y_reg + delta;
                    else if (event_code == AXIS_WHEEL)
                        sum_w_next = sum_w_reg + delta;
                end
                TYPE_KEY:
                begin
                    if (event_value != 32'sd0)
                    begin
                        pressed_next = pressed_reg | btn;
                        held_next    = held_reg | btn;
                    end
                    else if ((pressed_reg & btn) != 3'b000)
                    begin
                        deferred_next = deferred_reg | btn;
                    end
                    else
                    begin
                        released_next = released_reg | btn;
                        held_next     = held_reg & ~btn;
                    end
                end
                TYPE_SYNC:
                begin
                    pkt_valid     = 1'b1;
                    held_next     = held_reg & ~deferred_reg;
                    deferred_next = 3'b000;
                    sum_x_next    = 16'd0;
                    sum_y_next    = 16'd0;
                    sum_w_next    = 16'd0;
                    pressed_next  = 3'b000;
                    released_next = 3'b000;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg    <= 16'd0;
            sum_y_reg    <= 16'd0;
            sum_w_reg    <= 16'd0;
            pressed_reg  <= 3'b000;
            released_reg <= 3'b000;
            held_reg     <= 3'b000;
            deferred_reg <= 3'b000;
        end
        else
        begin
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            sum_w_reg    <= sum_w_next;
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
            held_reg     <= held_next;
            deferred_reg <= deferred_next;
        end
    end

endmodule

// ===== design/meba_queue.sv =====
// ----------------------------------------------------------------------------
// meba_queue
// Small packet queue between front and back.
// ----------------------------------------------------------------------------
module meba_queue
    import meba_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  packet_t       wdata,
    input  logic          pop,
    output packet_t       rdata,
    output queue_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    packet_t       mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign status.full  = (count_reg == FULL_COUNT);
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign rdata   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_COUNT)
        else $error("queue count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> !status.empty)
        else $error("queue empty after push");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push && count_reg == CW'(1)) |=> status.empty)
        else $error("queue not empty after last pop");

endmodule

// ===== design/meba_back.sv =====
// ----------------------------------------------------------------------------
// meba_back
// Expands queued packets into one or two result beats on the output register.
// ----------------------------------------------------------------------------
module meba_back
    import meba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  packet_t            q_data,
    input  logic               q_empty,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic signed [15:0] move_x,
    output logic signed [15:0] move_y,
    output logic signed [15:0] wheel_move,
    output logic [1:0]         packet_kind,
    output logic [2:0]         button_mask,
    output logic               last_packet
);

    logic               valid_reg;
    logic               pend_reg;
    logic [2:0]         pend_mask_reg;
    logic signed [15:0] x_reg, y_reg, w_reg;
    logic [1:0]         kind_reg;
    logic [2:0]         mask_reg;
    logic               last_reg;
    logic               slot_free;

    assign slot_free = !valid_reg || pop;
    assign q_pop     = slot_free && !pend_reg && !q_empty;

    assign empty       = !valid_reg;
    assign move_x      = x_reg;
    assign move_y      = y_reg;
    assign wheel_move  = w_reg;
    assign packet_kind = kind_reg;
    assign button_mask = mask_reg;
    assign last_packet = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            pend_mask_reg <= 3'b000;
        end
        else if (slot_free)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else if (!q_empty)
            begin
                valid_reg     <= 1'b1;
                pend_reg      <= (q_data.deferred != 3'b000);
                pend_mask_reg <= q_data.deferred;
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            if (pend_reg)
            begin
                x_reg    <= 16'sd0;
                y_reg    <= 16'sd0;
                w_reg    <= 16'sd0;
                kind_reg <= KIND_UP;
                mask_reg <= pend_mask_reg;
                last_reg <= 1'b1;
            end
            else if (!q_empty)
            begin
                x_reg    <= q_data.move_x;
                y_reg    <= q_data.move_y;
                w_reg    <= q_data.wheel_move;
                kind_reg <= q_data.kind;
                mask_reg <= q_data.mask;
                last_reg <= (q_data.deferred == 3'b000);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (valid_reg && !last_reg))
        else $error("deferred up pending without first beat shown");
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !last_reg) |-> pend_reg)
        else $error("non-final beat without deferred up behind it");
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && pop) |=> (valid_reg && last_reg && kind_reg == KIND_UP
                               && mask_reg != 3'b000))
        else $error("deferred up beat malformed");

endmodule

// ===== design/mouse_event_burst_assembler_unit.sv =====
// ----------------------------------------------------------------------------
// mouse_event_burst_assembler_unit
// Sums motion and tracks buttons over an event burst, emits packets on sync.
//
// Input channel: push/full queue. One event beat per cycle is taken whenever
// full is low; motion and button events only update internal state.
// Output channel: empty/pop queue. Each sync event yields one packet beat,
// or two when a release of a button pressed in the same burst was deferred
// (the second is a zero-motion up beat with last_packet set).
// An accepted sync's packet goes into the queue, then into the output
// register once it is free. Throughput: one event per cycle in, one result
// beat per cycle out while pop is high; a two-beat sync blocks the queue until
// its up beat shows. A packet queue of QUEUE_DEPTH entries sits between the
// event decoder and the result stage; full rises when it fills, e.g. while
// the receiver holds pop low or two-beat syncs arrive back to back.
// Reset clears all sums, masks, the queue and the output valid and pending flags.
// ----------------------------------------------------------------------------
module mouse_event_burst_assembler_unit
    import meba_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [15:0]        event_type,
    input  logic [15:0]        event_code,
    input  logic signed [31:0] event_value,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] move_x,
    output logic signed [15:0] move_y,
    output logic signed [15:0] wheel_move,
    output logic [1:0]         packet_kind,
    output logic [2:0]         button_mask,
    output logic               last_packet
);

    packet_t       front_pkt;
    logic          front_valid;
    packet_t       q_data;
    logic          q_pop;
    queue_status_t q_status;
    logic          accept;

    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    meba_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .pkt_valid   (front_valid),
        .pkt         (front_pkt)
    );

    meba_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (front_valid),
        .wdata  (front_pkt),
        .pop    (q_pop),
        .rdata  (q_data),
        .status (q_status)
    );

    meba_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (q_data),
        .q_empty     (q_status.empty),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .move_x      (move_x),
        .move_y      (move_y),
        .wheel_move  (wheel_move),
        .packet_kind (packet_kind),
        .button_mask (button_mask),
        .last_packet (last_packet)
    );

endmodule
